### rtl/g2dg_pkg.sv
package g2dg_pkg;

	localparam int MAX_DIGITS       = 20;
	localparam int POWER_TABLE_SIZE = 79;
	localparam int BCD_DIGITS       = 20;
	localparam int LEN_W            = $clog2(MAX_DIGITS + 1);
	localparam int POS_W            = $clog2(BCD_DIGITS);
	localparam int IDX_W            = $clog2(POWER_TABLE_SIZE);

	localparam logic signed [11:0] E_MIN = -12'sd1137;
	localparam logic signed [11:0] E_MAX = 12'sd960;
	localparam logic signed [30:0] LOG10_2_Q18 = 31'sd78913;
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(POWER_TABLE_SIZE - 1);

	typedef logic [BCD_DIGITS-1:0][3:0] digits_t;

	localparam logic [63:0] POW_SIG [POWER_TABLE_SIZE] = '{
		64'hAB70FE17C79AC6CA, 64'hFF77B1FCBEBCDC4F, 64'hBE5691EF416BD60C,
		64'h8DD01FAD907FFC3C, 64'hD3515C2831559A83, 64'h9D71AC8FADA6C9B5,
		64'hEA9C227723EE8BCB, 64'hAECC49914078536D, 64'h823C12795DB6CE57,
		64'hC21094364DFB5637, 64'h9096EA6F3848984F, 64'hD77485CB25823AC7,
		64'hA086CFCD97BF97F4, 64'hEF340A98172AACE5, 64'hB23867FB2A35B28E,
		64'h84C8D4DFD2C63F3B, 64'hC5DD44271AD3CDBA, 64'h936B9FCEBB25C996,
		64'hDBAC6C247D62A584, 64'hA3AB66580D5FDAF6, 64'hF3E2F893DEC3F126,
		64'hB5B5ADA8AAFF80B8, 64'h87625F056C7C4A8B, 64'hC9BCFF6034C13053,
		64'h964E858C91BA2655, 64'hDFF9772470297EBD, 64'hA6DFBD9FB8E5B88F,
		64'hF8A95FCF88747D94, 64'hB94470938FA89BCF, 64'h8A08F0F8BF0F156B,
		64'hCDB02555653131B6, 64'h993FE2C6D07B7FAC, 64'hE45C10C42A2B3B06,
		64'hAA242499697392D3, 64'hFD87B5F28300CA0E, 64'hBCE5086492111AEB,
		64'h8CBCCC096F5088CC, 64'hD1B71758E219652C, 64'h9C40000000000000,
		64'hE8D4A51000000000, 64'hAD78EBC5AC620000, 64'h813F3978F8940984,
		64'hC097CE7BC90715B3, 64'h8F7E32CE7BEA5C70, 64'hD5D238A4ABE98068,
		64'h9F4F2726179A2245, 64'hED63A231D4C4FB27, 64'hB0DE65388CC8ADA8,
		64'h83C7088E1AAB65DB, 64'hC45D1DF942711D9A, 64'h924D692CA61BE758,
		64'hDA01EE641A708DEA, 64'hA26DA3999AEF774A, 64'hF209787BB47D6B85,
		64'hB454E4A179DD1877, 64'h865B86925B9BC5C2, 64'hC83553C5C8965D3D,
		64'h952AB45CFA97A0B3, 64'hDE469FBD99A05FE3, 64'hA59BC234DB398C25,
		64'hF6C69A72A3989F5C, 64'hB7DCBF5354E9BECE, 64'h88FCF317F22241E2,
		64'hCC20CE9BD35C78A5, 64'h98165AF37B2153DF, 64'hE2A0B5DC971F303A,
		64'hA8D9D1535CE3B396, 64'hFB9B7CD9A4A7443C, 64'hBB764C4CA7A44410,
		64'h8BAB8EEFB6409C1A, 64'hD01FEF10A657842C, 64'h9B10A4E5E9913129,
		64'hE7109BFBA19C0C9D, 64'hAC2820D9623BF429, 64'h80444B5E7AA7CF85,
		64'hBF21E44003ACDD2D, 64'h8E679C2F5E44FF8F, 64'hD433179D9C8CB841,
		64'h9E19DB92B4E31BA9
	};

	localparam logic signed [11:0] POW_EXP [POWER_TABLE_SIZE] = '{
		-12'sd1060, -12'sd1034, -12'sd1007, -12'sd980, -12'sd954, -12'sd927,
		-12'sd901, -12'sd874, -12'sd847, -12'sd821, -12'sd794, -12'sd768,
		-12'sd741, -12'sd715, -12'sd688, -12'sd661, -12'sd635, -12'sd608,
		-12'sd582, -12'sd555, -12'sd529, -12'sd502, -12'sd475, -12'sd449,
		-12'sd422, -12'sd396, -12'sd369, -12'sd343, -12'sd316, -12'sd289,
		-12'sd263, -12'sd236, -12'sd210, -12'sd183, -12'sd157, -12'sd130,
		-12'sd103, -12'sd77, -12'sd50, -12'sd24, 12'sd3, 12'sd30,
		12'sd56, 12'sd83, 12'sd109, 12'sd136, 12'sd162, 12'sd189,
		12'sd216, 12'sd242, 12'sd269, 12'sd295, 12'sd322, 12'sd348,
		12'sd375, 12'sd402, 12'sd428, 12'sd455, 12'sd481, 12'sd508,
		12'sd534, 12'sd561, 12'sd588, 12'sd614, 12'sd641, 12'sd667,
		12'sd694, 12'sd720, 12'sd747, 12'sd774, 12'sd800, 12'sd827,
		12'sd853, 12'sd880, 12'sd907, 12'sd933, 12'sd960, 12'sd986,
		12'sd1013
	};

	// powers of ten, the last one wraps modulo 2^64
	function automatic logic [63:0] pow10(input logic [4:0] n);
		logic [63:0] r;
		unique case (n)
			5'd0:    r = 64'd1;
			5'd1:    r = 64'd10;
			5'd2:    r = 64'd100;
			5'd3:    r = 64'd1000;
			5'd4:    r = 64'd10000;
			5'd5:    r = 64'd100000;
			5'd6:    r = 64'd1000000;
			5'd7:    r = 64'd10000000;
			5'd8:    r = 64'd100000000;
			5'd9:    r = 64'd1000000000;
			5'd10:   r = 64'd10000000000;
			5'd11:   r = 64'd100000000000;
			5'd12:   r = 64'd1000000000000;
			5'd13:   r = 64'd10000000000000;
			5'd14:   r = 64'd100000000000000;
			5'd15:   r = 64'd1000000000000000;
			5'd16:   r = 64'd10000000000000000;
			5'd17:   r = 64'd100000000000000000;
			5'd18:   r = 64'd1000000000000000000;
			5'd19:   r = 64'd10000000000000000000;
			5'd20:   r = 64'h6BC75E2D63100000;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

endpackage

### rtl/grisu2_digit_generator_core.sv
// sequence: from an accepted transaction to the first digit the core scales the three
//   significands on the shared 32x32 multiplier, runs the binary to bcd converter, cuts
//   digits and strips zeros or generates the fractional digits, and applies the
//   rounding steps
// throughput: one conversion at a time, item_stall is high from accept until the last
//   digit transaction; digits then leave at one per cycle while result_stall is low
// reset: arst_n clears the sequencer to idle, no clearing pass
module grisu2_digit_generator_core import g2dg_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  logic [63:0]        lower_significand,
	input  logic [63:0]        value_significand,
	input  logic [63:0]        upper_significand,
	input  logic signed [11:0] binary_exponent,
	output logic               result_valid,
	input  logic               result_stall,
	output logic [3:0]         digit,
	output logic [4:0]         digit_position,
	output logic               is_last,
	output logic [4:0]         digit_count,
	output logic signed [9:0]  ten_exponent
);

	localparam logic [4:0] ST_IDLE  = 5'd0;
	localparam logic [4:0] ST_IDX0  = 5'd1;
	localparam logic [4:0] ST_IDX1  = 5'd2;
	localparam logic [4:0] ST_IDX2  = 5'd3;
	localparam logic [4:0] ST_MUL   = 5'd4;
	localparam logic [4:0] ST_PREP0 = 5'd5;
	localparam logic [4:0] ST_PREP1 = 5'd6;
	localparam logic [4:0] ST_SPLIT = 5'd7;
	localparam logic [4:0] ST_COUNT = 5'd8;
	localparam logic [4:0] ST_BCDW  = 5'd9;
	localparam logic [4:0] ST_CUT   = 5'd10;
	localparam logic [4:0] ST_STRIP = 5'd11;
	localparam logic [4:0] ST_IFIN  = 5'd12;
	localparam logic [4:0] ST_FMUL  = 5'd13;
	localparam logic [4:0] ST_FDIG  = 5'd14;
	localparam logic [4:0] ST_FCMP  = 5'd15;
	localparam logic [4:0] ST_DEC   = 5'd16;
	localparam logic [4:0] ST_OUT   = 5'd17;

	logic [4:0]         state_q;
	logic [63:0]        ls_q, vs_q, us_q;
	logic signed [11:0] e_q;
	logic signed [30:0] prod_q;
	logic [IDX_W-1:0]   idx_q;
	logic [63:0]        cf_q;
	logic [5:0]         s_q;
	logic signed [9:0]  dec_q;
	logic [1:0]         msel_q;
	logic [2:0]         mstep_q;
	logic [33:0]        mid_q;
	logic [63:0]        hi_q;
	logic [63:0]        wl_q, wv_q, wu_q;
	logic [63:0]        delta_q, dist_q, p2_q, ds_q, rem_q, rest_q, t_q;
	logic [4:0]         power_q, cnt_q;
	logic               intg_q;
	logic [LEN_W-1:0]   len_q, oi_q;
	digits_t            digits_q;

	// index and scale computation
	logic signed [12:0] fi_w;
	logic signed [30:0] prod_w;
	logic [30:0]        prod_mag;
	logic signed [13:0] kpos, k_w, t_w;
	logic [10:0]        q_w;
	logic [IDX_W-1:0]   idx_w;
	logic signed [13:0] sexp_w;

	assign fi_w     = -13'sd61 - 13'(e_q);
	assign prod_w   = 31'(fi_w) * LOG10_2_Q18;
	assign prod_mag = prod_q[30] ? 31'(-prod_q) : 31'(prod_q);
	assign kpos     = signed'({1'b0, prod_mag[30:18]});
	assign k_w      = prod_q[30] ? -kpos : kpos + 14'(prod_q != '0);
	assign t_w      = 14'sd307 + k_w;
	assign q_w      = t_w[13:3];
	always_comb begin
		if (t_w < 0)
			idx_w = '0;
		else if (q_w > 11'(IDX_LAST))
			idx_w = IDX_LAST;
		else
			idx_w = IDX_W'(q_w);
	end
	assign sexp_w = 14'(POW_EXP[idx_q]) + 14'(e_q) + 14'sd64;

	// shared multiplier, partial products of the rounded upper half
	logic [63:0] mop_w, pp_w;
	logic [31:0] ma_w, mb_w;
	logic [63:0] mres_w;

	always_comb begin
		unique case (msel_q)
			2'd0:    mop_w = ls_q;
			2'd1:    mop_w = vs_q;
			default: mop_w = us_q;
		endcase
		unique case (mstep_q)
			3'd0:    begin ma_w = mop_w[31:0];  mb_w = cf_q[31:0];  end
			3'd1:    begin ma_w = mop_w[63:32]; mb_w = cf_q[31:0];  end
			3'd2:    begin ma_w = mop_w[31:0];  mb_w = cf_q[63:32]; end
			default: begin ma_w = mop_w[63:32]; mb_w = cf_q[63:32]; end
		endcase
	end

	g2dg_mul u_mul (
		.clk     (clk),
		.a       (ma_w),
		.b       (mb_w),
		.product (pp_w)
	);

	assign mres_w = hi_q + {62'd0, mid_q[33:32]};

	// binary to bcd for the integral part
	logic    bcd_start_w, bcd_done_w;
	digits_t bcd_digits_w;

	assign bcd_start_w = (state_q == ST_PREP1);

	g2dg_bcd u_bcd (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (bcd_start_w),
		.value  (wu_q >> s_q),
		.done   (bcd_done_w),
		.digits (bcd_digits_w)
	);

	function automatic logic [LEN_W-1:0] ndig(digits_t d);
		logic [LEN_W-1:0] n;
		n = LEN_W'(1);
		for (int i = 1; i < BCD_DIGITS; i++) begin
			if (d[i] != 4'd0)
				n = LEN_W'(i + 1);
		end
		return n;
	endfunction

	logic [63:0] mask_w, cut_add_w, dr_w, dl_w, rt_w;
	logic        c4_w, dec_ok_w;

	assign mask_w    = (64'd1 << s_q) - 64'd1;
	assign cut_add_w = rem_q + pow10(cnt_q) * {60'd0, digits_q[0]};
	assign dr_w      = dist_q - rest_q;
	assign dl_w      = delta_q - rest_q;
	assign rt_w      = rest_q + t_q;
	assign c4_w      = intg_q ? ((t_q >> 1) < dr_w)
	                          : ((rt_w < dist_q) || (dr_w > (rt_w - dist_q)));
	assign dec_ok_w  = (digits_q[0] != 4'd0) && (rest_q < dist_q) && (dl_w >= t_q) && c4_w;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (item_valid) state_q <= ST_IDX0;
				ST_IDX0:  state_q <= ST_IDX1;
				ST_IDX1:  state_q <= ST_IDX2;
				ST_IDX2:  state_q <= ST_MUL;
				ST_MUL:   if (mstep_q == 3'd5 && msel_q == 2'd2) state_q <= ST_PREP0;
				ST_PREP0: state_q <= ST_PREP1;
				ST_PREP1: state_q <= ST_SPLIT;
				ST_SPLIT: state_q <= (delta_q >= p2_q) ? ST_COUNT : ST_BCDW;
				ST_COUNT: begin
					if (ds_q == '0 || cnt_q > 5'd19 || ds_q < pow10(cnt_q))
						state_q <= ST_BCDW;
				end
				ST_BCDW: begin
					if (bcd_done_w) begin
						if (!intg_q)
							state_q <= ST_FMUL;
						else if (power_q == '0)
							state_q <= ST_STRIP;
						else
							state_q <= ST_CUT;
					end
				end
				ST_CUT: begin
					if (cnt_q == power_q - 5'd1)
						state_q <= (cut_add_w > ds_q) ? ST_IFIN : ST_STRIP;
				end
				ST_STRIP: begin
					if (digits_q == '0 || digits_q[0] != 4'd0)
						state_q <= ST_IFIN;
				end
				ST_IFIN:  state_q <= (dist_q > p2_q) ? ST_DEC : ST_OUT;
				ST_FMUL:  state_q <= (len_q < LEN_W'(MAX_DIGITS)) ? ST_FDIG : ST_OUT;
				ST_FDIG:  state_q <= ST_FCMP;
				ST_FCMP:  state_q <= (p2_q <= delta_q) ? ST_DEC : ST_FMUL;
				ST_DEC:   if (!dec_ok_w) state_q <= ST_OUT;
				ST_OUT: begin
					if (!result_stall && oi_q == len_q - LEN_W'(1))
						state_q <= ST_IDLE;
				end
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				ls_q <= lower_significand;
				vs_q <= value_significand;
				us_q <= upper_significand;
				oi_q <= '0;
				if (binary_exponent < E_MIN)
					e_q <= E_MIN;
				else if (binary_exponent > E_MAX)
					e_q <= E_MAX;
				else
					e_q <= binary_exponent;
			end
			ST_IDX0: prod_q <= prod_w;
			ST_IDX1: idx_q <= idx_w;
			ST_IDX2: begin
				cf_q    <= POW_SIG[idx_q];
				s_q     <= 6'(-sexp_w);
				dec_q   <= 10'(11'sd300 - signed'({1'b0, idx_q, 3'b000}));
				msel_q  <= '0;
				mstep_q <= '0;
			end
			ST_MUL: begin
				mstep_q <= (mstep_q == 3'd5) ? 3'd0 : mstep_q + 3'd1;
				unique case (mstep_q)
					3'd1: begin
						mid_q <= {2'b00, pp_w[63:32]} + 34'h80000000;
						hi_q  <= '0;
					end
					3'd2, 3'd3: begin
						mid_q <= mid_q + {2'b00, pp_w[31:0]};
						hi_q  <= hi_q + {32'd0, pp_w[63:32]};
					end
					3'd4: hi_q <= hi_q + pp_w;
					3'd5: begin
						msel_q <= msel_q + 2'd1;
						unique case (msel_q)
							2'd0:    wl_q <= mres_w + 64'd1;
							2'd1:    wv_q <= mres_w;
							default: wu_q <= mres_w - 64'd1;
						endcase
					end
					default: ;
				endcase
			end
			ST_PREP0: begin
				delta_q <= wu_q - wl_q;
				dist_q  <= wu_q - wv_q;
			end
			ST_PREP1: p2_q <= wu_q & mask_w;
			ST_SPLIT: begin
				intg_q  <= (delta_q >= p2_q);
				ds_q    <= (delta_q - p2_q) >> s_q;
				cnt_q   <= 5'd1;
				power_q <= '0;
				rem_q   <= '0;
			end
			ST_COUNT: begin
				// number of decimal digits of ds
				if (ds_q == '0) begin
					power_q <= '0;
				end else if (cnt_q > 5'd19 || ds_q < pow10(cnt_q)) begin
					power_q <= cnt_q;
					cnt_q   <= '0;
				end else begin
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_BCDW: begin
				if (bcd_done_w) begin
					digits_q <= bcd_digits_w;
					len_q    <= ndig(bcd_digits_w);
					cnt_q    <= '0;
				end
			end
			ST_CUT: begin
				// drop one low digit per cycle, keeping its weight in rem
				if (cnt_q != power_q - 5'd1) begin
					rem_q    <= cut_add_w;
					digits_q <= {4'h0, digits_q[BCD_DIGITS-1:1]};
					cnt_q    <= cnt_q + 5'd1;
				end else if (cut_add_w > ds_q) begin
					power_q <= power_q - 5'd1;
				end else begin
					rem_q    <= cut_add_w;
					digits_q <= {4'h0, digits_q[BCD_DIGITS-1:1]};
				end
			end
			ST_STRIP: begin
				if (digits_q != '0 && digits_q[0] == 4'd0) begin
					digits_q <= {4'h0, digits_q[BCD_DIGITS-1:1]};
					power_q  <= power_q + 5'd1;
				end
			end
			ST_IFIN: begin
				len_q  <= ndig(digits_q);
				dec_q  <= dec_q + 10'(power_q);
				rest_q <= (rem_q << s_q) + p2_q;
				t_q    <= pow10(power_q) << s_q;
			end
			ST_FMUL: begin
				if (len_q < LEN_W'(MAX_DIGITS)) begin
					p2_q    <= (p2_q << 3) + (p2_q << 1);
					delta_q <= (delta_q << 3) + (delta_q << 1);
					dist_q  <= (dist_q << 3) + (dist_q << 1);
				end
			end
			ST_FDIG: begin
				digits_q <= {digits_q[BCD_DIGITS-2:0], 4'(p2_q >> s_q)};
				len_q    <= len_q + LEN_W'(1);
				p2_q     <= p2_q & mask_w;
				dec_q    <= dec_q - 10'sd1;
			end
			ST_FCMP: begin
				rest_q <= p2_q;
				t_q    <= 64'd1 << s_q;
			end
			ST_DEC: begin
				// closer-rounding decrement of the last digit
				if (dec_ok_w) begin
					digits_q[0] <= digits_q[0] - 4'd1;
					rest_q      <= rt_w;
				end
			end
			ST_OUT: if (!result_stall) oi_q <= oi_q + LEN_W'(1);
			default: ;
		endcase
	end

	logic [POS_W-1:0] out_idx_w;
	logic             last_w;

	assign out_idx_w      = POS_W'(len_q - LEN_W'(1) - oi_q);
	assign last_w         = (oi_q == len_q - LEN_W'(1));
	assign item_stall     = (state_q != ST_IDLE);
	assign result_valid   = (state_q == ST_OUT);
	assign digit          = digits_q[out_idx_w];
	assign digit_position = 5'(oi_q);
	assign is_last        = last_w;
	assign digit_count    = last_w ? 5'(len_q) : 5'd0;
	assign ten_exponent   = last_w ? dec_q : 10'sd0;

endmodule

### rtl/g2dg_mul.sv
module g2dg_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] product
);

	logic [63:0] product_q;

	always_ff @(posedge clk) begin
		product_q <= {32'd0, a} * {32'd0, b};
	end

	assign product = product_q;

endmodule

### rtl/g2dg_bcd.sv
module g2dg_bcd import g2dg_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] value,
	output logic        done,
	output digits_t     digits
);

	logic [63:0] bin_q;
	digits_t     bcd_q;
	logic [4:0]  cnt_q;
	logic        run_q;
	logic        done_q;

	function automatic digits_t dabble(digits_t d, logic b);
		digits_t r;
		r = d;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			if (r[i] >= 4'd5)
				r[i] = r[i] + 4'd3;
		end
		return digits_t'({r, b});
	endfunction

	// two bits per cycle until the whole word is shifted through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bin_q <= value;
			bcd_q <= '0;
		end else if (run_q) begin
			bin_q <= {bin_q[61:0], 2'b00};
			bcd_q <= dabble(dabble(bcd_q, bin_q[63]), bin_q[62]);
		end
	end

	assign done   = done_q;
	assign digits = bcd_q;

endmodule
